/* sv/vsce_pkg.sv */
// shared types and constants of the vme stack command encoder
package vsce_pkg;

    // mode word flags
    localparam logic [31:0] MODE_NW    = 32'h0000_0100;
    localparam logic [31:0] MODE_NA    = 32'h0000_0400;
    localparam logic [31:0] MODE_MB    = 32'h0000_0800;
    localparam logic [31:0] MODE_SLF   = 32'h0000_1000;
    localparam logic [31:0] MODE_MARK  = 32'h0000_2000;
    localparam logic [31:0] MODE_DELAY = 32'h0000_8000;
    localparam logic [31:0] MODE_ND    = 32'h0004_0000;

    // multiblock transfer counts at bit 24: 64 longwords or 128 words per 256-byte block
    localparam logic [31:0] BLT_PER_BLOCK_32 = 32'h4000_0000;
    localparam logic [31:0] BLT_PER_BLOCK_16 = 32'h8000_0000;

    // widest transfer count field on the request
    localparam int REQ_COUNT_BITS = 24;

    // requested operations
    typedef enum logic [3:0] {
        ACT_REGRD     = 4'd0,
        ACT_REGWR     = 4'd1,
        ACT_WR32      = 4'd2,
        ACT_WR16      = 4'd3,
        ACT_WR8       = 4'd4,
        ACT_RD32      = 4'd5,
        ACT_RD16      = 4'd6,
        ACT_RD8       = 4'd7,
        ACT_BLKRD32   = 4'd8,
        ACT_FIFO32    = 4'd9,
        ACT_FIFO16    = 4'd10,
        ACT_DELAY     = 4'd11,
        ACT_MARKER    = 4'd12,
        ACT_COUNTRD8  = 4'd13,
        ACT_COUNTRD16 = 4'd14,
        ACT_COUNTRD32 = 4'd15
    } t_action;

    // word slots of one request, in emission order
    typedef enum logic [2:0] {
        SLOT_ALIGN_MODE = 3'd0,
        SLOT_ALIGN_ADDR = 3'd1,
        SLOT_MB_MODE    = 3'd2,
        SLOT_MB_COUNT   = 3'd3,
        SLOT_MB_ADDR    = 3'd4,
        SLOT_PART_MODE  = 3'd5,
        SLOT_PART_ADDR  = 3'd6
    } t_slot;

    // classified request handed from the front to the sequencer
    typedef struct packed {
        logic        blk;      // block or fifo read
        logic        wide;     // 32-bit block transfers
        logic        na;       // no address increment
        logic        nl;       // not-longword indicator
        logic [6:0]  present;  // slots that carry a word
        logic [6:0]  align;    // aligning transfer count
        logic [6:0]  part;     // trailing partial block count
        logic [31:0] w0;       // first word, or block mode base
        logic [31:0] w1;       // second word, or block base address
        logic [31:0] w2;       // third word, or whole block count
    } t_desc;

endpackage

/* sv/vsce_if.sv */
// request and stack word channel interfaces

interface vsce_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [31:0] bus_address;
    logic [5:0]  addr_modifier;
    logic [31:0] data_value;
    logic [23:0] transfer_count;
    logic [31:0] count_mask;

    modport source (
        output valid, action, bus_address, addr_modifier, data_value,
               transfer_count, count_mask,
        input  ready
    );
    modport sink (
        input  valid, action, bus_address, addr_modifier, data_value,
               transfer_count, count_mask,
        output ready
    );
endinterface

interface vsce_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] stack_word;
    logic        last_word;

    modport source (
        output valid, stack_word, last_word,
        input  ready
    );
    modport sink (
        input  valid, stack_word, last_word,
        output ready
    );
endinterface

/* sv/vsce_front.sv */
// request classifier: decodes the operation and splits block reads
module vsce_front #(
    parameter int COUNT_WIDTH = 24
) (
    vsce_req_if.sink       i_req,
    input  logic           i_full,
    output logic           o_push,
    output vsce_pkg::t_desc o_desc
);

    localparam int CW = (COUNT_WIDTH < vsce_pkg::REQ_COUNT_BITS) ?
                        COUNT_WIDTH : vsce_pkg::REQ_COUNT_BITS;

    logic [31:0]   addr;
    logic [31:0]   data;
    logic [31:0]   am;
    logic [31:0]   strb;
    logic [31:0]   a4;
    logic [31:0]   a2;
    logic [7:0]    off;
    logic [8:0]    align_raw;
    logic [6:0]    align_max;
    logic [6:0]    align_sel;
    logic [CW-1:0] count;
    logic [CW-1:0] rem;
    logic [CW-1:0] full;
    logic [6:0]    part;
    logic          wide;
    logic [31:0]   blk_mode;
    vsce_pkg::t_desc desc;

    // request fields and derived addresses
    assign addr  = i_req.bus_address;
    assign data  = i_req.data_value;
    assign am    = {26'd0, i_req.addr_modifier};
    assign strb  = {24'd0, (addr[0] ? 2'b01 : 2'b10), 6'd0};
    assign a4    = {addr[31:2], 2'b00};
    assign a2    = {addr[31:1], 1'b1};
    assign count = i_req.transfer_count[CW-1:0];
    assign off   = addr[7:0];

    // aligning transfer up to the next 256-byte boundary, limited by the count
    assign wide      = (vsce_pkg::t_action'(i_req.action) != vsce_pkg::ACT_FIFO16);
    assign align_raw = 9'd256 - {1'b0, off};
    assign align_max = (off == 8'd0) ? 7'd0 :
                       (wide ? {1'b0, align_raw[7:2]} : align_raw[7:1]);
    assign align_sel = (count < {{(CW-7){1'b0}}, align_max}) ? count[6:0] : align_max;
    assign rem       = count - {{(CW-7){1'b0}}, align_sel};

    // whole blocks and trailing partial block
    assign full = wide ? (rem >> 6) : (rem >> 7);
    assign part = wide ? {1'b0, rem[5:0]} : rem[6:0];

    // classify the operation
    always_comb begin
        blk_mode     = vsce_pkg::MODE_NW | am;
        desc         = '0;
        desc.wide    = wide;
        desc.align   = align_sel;
        desc.part    = part;
        desc.w1      = addr;
        case (vsce_pkg::t_action'(i_req.action))
            vsce_pkg::ACT_REGRD: begin
                desc.w0 = vsce_pkg::MODE_NW | vsce_pkg::MODE_SLF;
                desc.present = 7'b0000011;
            end
            vsce_pkg::ACT_REGWR: begin
                desc.w0 = vsce_pkg::MODE_SLF;
                desc.w2 = data;
                desc.present = 7'b0000111;
            end
            vsce_pkg::ACT_WR32: begin
                desc.w0 = am;
                desc.w1 = a4;
                desc.w2 = data;
                desc.present = 7'b0000111;
            end
            vsce_pkg::ACT_WR16: begin
                desc.w0 = am;
                desc.w1 = a2;
                desc.w2 = {16'd0, data[15:0]};
                desc.present = 7'b0000111;
            end
            vsce_pkg::ACT_WR8: begin
                desc.w0 = am | strb;
                desc.w1 = a2;
                desc.w2 = {16'd0, data[7:0], data[7:0]};
                desc.present = 7'b0000111;
            end
            vsce_pkg::ACT_RD32: begin
                desc.w0 = vsce_pkg::MODE_NW | am;
                desc.w1 = a4;
                desc.present = 7'b0000011;
            end
            vsce_pkg::ACT_RD16: begin
                desc.w0 = vsce_pkg::MODE_NW | am;
                desc.w1 = a2;
                desc.present = 7'b0000011;
            end
            vsce_pkg::ACT_RD8: begin
                desc.w0 = vsce_pkg::MODE_NW | am | strb;
                desc.w1 = a2;
                desc.present = 7'b0000011;
            end
            vsce_pkg::ACT_BLKRD32, vsce_pkg::ACT_FIFO32, vsce_pkg::ACT_FIFO16: begin
                desc.blk = 1'b1;
                desc.na  = (vsce_pkg::t_action'(i_req.action) != vsce_pkg::ACT_BLKRD32);
                desc.nl  = !wide;
                desc.w0  = desc.na ? (blk_mode | vsce_pkg::MODE_NA) : blk_mode;
                desc.w2  = {{(32-CW){1'b0}}, full};
                desc.present = {{2{part != 7'd0}}, {3{full != '0}}, {2{off != 8'd0}}};
            end
            vsce_pkg::ACT_DELAY: begin
                desc.w0 = vsce_pkg::MODE_DELAY | {24'd0, data[7:0]};
                desc.present = 7'b0000001;
            end
            vsce_pkg::ACT_MARKER: begin
                desc.w0 = vsce_pkg::MODE_MARK;
                desc.w1 = {16'd0, data[15:0]};
                desc.present = 7'b0000011;
            end
            vsce_pkg::ACT_COUNTRD8: begin
                desc.w0 = vsce_pkg::MODE_NW | vsce_pkg::MODE_ND | am | strb;
                desc.w1 = i_req.count_mask;
                desc.w2 = a2;
                desc.present = 7'b0000111;
            end
            vsce_pkg::ACT_COUNTRD16: begin
                desc.w0 = vsce_pkg::MODE_NW | vsce_pkg::MODE_ND | am;
                desc.w1 = i_req.count_mask;
                desc.w2 = a2;
                desc.present = 7'b0000111;
            end
            default: begin
                desc.w0 = vsce_pkg::MODE_NW | vsce_pkg::MODE_ND | am;
                desc.w1 = i_req.count_mask;
                desc.w2 = a4;
                desc.present = 7'b0000111;
            end
        endcase
    end

    // hand over; an empty block request produces nothing and is dropped
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full && (desc.present != 7'd0);
    assign o_desc      = desc;

endmodule

/* sv/vsce_queue.sv */
// two-entry queue of classified requests between front and sequencer
module vsce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vsce_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output vsce_pkg::t_desc o_head
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    vsce_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

/* sv/vsce_back.sv */
// command sequencer: emits the stack words of one request, one per cycle unless output stalls
module vsce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  vsce_pkg::t_desc i_head,
    output logic            o_pop,
    vsce_rsp_if.source      o_rsp
);

    logic            r_busy;
    vsce_pkg::t_slot r_slot;
    logic [31:0]     r_addr;
    logic            r_out_valid;
    logic [31:0]     r_out_word;
    logic            r_out_last;
    logic            advance;
    logic            load;
    logic            last;
    vsce_pkg::t_slot next_slot;
    vsce_pkg::t_slot first_slot;
    logic [31:0]     word;
    logic [31:0]     align_bytes;
    logic [31:0]     mb_bytes;
    logic [31:0]     nl_bit;

    // output register is free when empty or being taken
    assign advance = !r_out_valid || o_rsp.ready;
    assign load    = r_busy && advance;

    // next present slot after the current one, and the first of a new request
    always_comb begin
        next_slot  = r_slot;
        first_slot = vsce_pkg::SLOT_ALIGN_MODE;
        last       = 1'b1;
        for (int k = 6; k >= 0; k--) begin
            if (i_head.present[k] && (3'(k) > r_slot)) begin
                next_slot = vsce_pkg::t_slot'(3'(k));
                last      = 1'b0;
            end
            if (i_head.present[k]) begin
                first_slot = vsce_pkg::t_slot'(3'(k));
            end
        end
    end

    // address steps of a block read
    assign align_bytes = i_head.wide ? {23'd0, i_head.align, 2'b00} :
                                       {24'd0, i_head.align, 1'b0};
    assign mb_bytes    = {i_head.w2[23:0], 8'd0};
    assign nl_bit      = {31'd0, i_head.nl};

    // word of the current slot
    always_comb begin
        case (r_slot)
            vsce_pkg::SLOT_ALIGN_MODE:
                word = i_head.blk ? (i_head.w0 | {1'b0, i_head.align, 24'd0}) : i_head.w0;
            vsce_pkg::SLOT_ALIGN_ADDR:
                word = i_head.blk ? (i_head.w1 | nl_bit) : i_head.w1;
            vsce_pkg::SLOT_MB_MODE:
                word = i_head.blk ? (i_head.w0 | vsce_pkg::MODE_MB |
                       (i_head.wide ? vsce_pkg::BLT_PER_BLOCK_32 :
                                      vsce_pkg::BLT_PER_BLOCK_16)) : i_head.w2;
            vsce_pkg::SLOT_MB_COUNT:
                word = i_head.w2;
            vsce_pkg::SLOT_PART_MODE:
                word = i_head.w0 | {1'b0, i_head.part, 24'd0};
            default:
                word = r_addr | nl_bit;
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= vsce_pkg::SLOT_ALIGN_MODE;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            if (load) begin
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_slot <= next_slot;
                end
            end else if (!r_busy && i_head_valid) begin
                r_busy <= 1'b1;
                r_slot <= first_slot;
            end
        end
    end

    // running block address and output payload
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_head_valid) begin
            r_addr <= i_head.w1 + align_bytes;
        end else if (load && (r_slot == vsce_pkg::SLOT_MB_ADDR) && !i_head.na) begin
            r_addr <= r_addr + mb_bytes;
        end
        if (load) begin
            r_out_word <= word;
            r_out_last <= last;
        end
    end

    assign o_pop            = load && last;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.stack_word = r_out_word;
    assign o_rsp.last_word  = r_out_last;

    // a busy sequencer always works on a queued request
    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> i_head_valid)
        else $error("sequencer busy without a queued request");

    // the current slot is one that carries a word
    a_slot_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> i_head.present[r_slot])
        else $error("sequencer on an empty slot");

    // the final word frees the sequencer
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> !r_busy)
        else $error("sequencer still busy after final word");

    // the last flag of a loaded word marks the request release
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_out_valid && (r_out_last == $past(o_pop))))
        else $error("last word flag disagrees with request release");

endmodule

/* sv/vme_stack_command_encoder.sv */
// top level of the vme stack command encoder
// Takes one bus operation request and returns its command-list longwords in order on a
// one-word result channel, with last_word set on the final word of each request. The
// front decodes a request in the cycle it is accepted and places it in a two-entry queue,
// so requests are taken while earlier ones are still being emitted. The sequencer takes
// a request from the queue when idle, then emits one word per cycle while the result
// channel accepts them; a request has from one word for a delay up to seven for a block
// read split into aligning, multiblock and trailing transfers. An aligned block or fifo
// read of zero transfers produces no words.
module vme_stack_command_encoder #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vsce_req_if.sink   i_req,
    vsce_rsp_if.source o_rsp
);

    logic            push;
    logic            pop;
    logic            full;
    logic            head_valid;
    vsce_pkg::t_desc desc;
    vsce_pkg::t_desc head;

    // request classifier
    vsce_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_desc (desc)
    );

    // queue between classifier and sequencer
    vsce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // word sequencer
    vsce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_rsp        (o_rsp)
    );

endmodule

/* verif/tb.sv */
// testbench for the vme stack command encoder: random and directed requests against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DUT_COUNT_WIDTH = 24;
    localparam int          RANDOM_REQUESTS = 305;
    localparam int          PHASE_LEN       = 30;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          MAX_REPORTS     = 10;
    localparam int          BLT_SHIFT       = 24;
    localparam logic [31:0] STROBE_ODD      = 32'h0000_0040;
    localparam logic [31:0] STROBE_EVEN     = 32'h0000_0080;
    localparam logic [31:0] LONG_ALIGN_MASK = 32'hffff_fffc;

    typedef struct {
        vsce_pkg::t_action action;
        logic [31:0]       addr;
        logic [5:0]        am;
        logic [31:0]       data;
        logic [23:0]       count;
        logic [31:0]       mask;
    } t_bus_request;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } t_stack_entry;

    // expected stack words and the encoding that produces them
    class stack_word_board;
        t_stack_entry expected_words[$];
        logic [31:0]  burst[$];
        int           failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // append one word to the words of the current request
        function void add_word(logic [31:0] w);
            burst.insert(burst.size(), w);
        endfunction

        function logic [31:0] strobe_code(logic [31:0] a);
            return a[0] ? STROBE_ODD : STROBE_EVEN;
        endfunction

        // aligning partial block, whole blocks, trailing partial block
        function void encode_block(logic [31:0] base, logic [31:0] cnt, logic [31:0] start,
                                   int unsigned width);
            logic [31:0] per_block, nl, off, align_n, full, part;
            per_block = 256 / width;
            nl        = (width != 4) ? 32'd1 : 32'd0;
            off       = {24'd0, base[7:0]};
            if (off != 0) begin
                align_n = (32'd256 - off) / width;
                if (cnt < align_n) align_n = cnt;
                add_word(start | (align_n << BLT_SHIFT));
                add_word(base | nl);
                base = base + align_n * width;
                cnt  = cnt - align_n;
            end
            if (cnt == 0) return;
            full = cnt / per_block;
            part = cnt % per_block;
            if (full != 0) begin
                add_word(start | vsce_pkg::MODE_MB | (per_block << BLT_SHIFT));
                add_word(full);
                add_word(base | nl);
                if ((start & vsce_pkg::MODE_NA) == 0) base = base + full * 256;
            end
            if (part != 0) begin
                add_word(start | (part << BLT_SHIFT));
                add_word(base | nl);
            end
        endfunction

        // work out the words of one accepted request
        function void note_request(t_bus_request r);
            logic [31:0]  a4, a2, am, cnt, b;
            t_stack_entry e;
            a4  = r.addr & LONG_ALIGN_MASK;
            a2  = {r.addr[31:1], 1'b1};
            am  = {26'd0, r.am};
            cnt = 32'(64'(r.count) & ((64'd1 << DUT_COUNT_WIDTH) - 64'd1));
            b   = {24'd0, r.data[7:0]};
            burst.delete();
            case (r.action)
                vsce_pkg::ACT_REGRD: begin
                    add_word(vsce_pkg::MODE_NW | vsce_pkg::MODE_SLF); add_word(r.addr);
                end
                vsce_pkg::ACT_REGWR: begin
                    add_word(vsce_pkg::MODE_SLF); add_word(r.addr);
                    add_word(r.data);
                end
                vsce_pkg::ACT_WR32: begin
                    add_word(am); add_word(a4); add_word(r.data);
                end
                vsce_pkg::ACT_WR16: begin
                    add_word(am); add_word(a2);
                    add_word({16'd0, r.data[15:0]});
                end
                vsce_pkg::ACT_WR8: begin
                    add_word(am | strobe_code(r.addr)); add_word(a2);
                    add_word(b | (b << 8));
                end
                vsce_pkg::ACT_RD32: begin
                    add_word(vsce_pkg::MODE_NW | am); add_word(a4);
                end
                vsce_pkg::ACT_RD16: begin
                    add_word(vsce_pkg::MODE_NW | am); add_word(a2);
                end
                vsce_pkg::ACT_RD8: begin
                    add_word(vsce_pkg::MODE_NW | am | strobe_code(r.addr)); add_word(a2);
                end
                vsce_pkg::ACT_BLKRD32:
                    encode_block(r.addr, cnt, vsce_pkg::MODE_NW | am, 4);
                vsce_pkg::ACT_FIFO32:
                    encode_block(r.addr, cnt, vsce_pkg::MODE_NA | vsce_pkg::MODE_NW | am, 4);
                vsce_pkg::ACT_FIFO16:
                    encode_block(r.addr, cnt, vsce_pkg::MODE_NA | vsce_pkg::MODE_NW | am, 2);
                vsce_pkg::ACT_DELAY:
                    add_word(vsce_pkg::MODE_DELAY | b);
                vsce_pkg::ACT_MARKER: begin
                    add_word(vsce_pkg::MODE_MARK); add_word({16'd0, r.data[15:0]});
                end
                vsce_pkg::ACT_COUNTRD8: begin
                    add_word(vsce_pkg::MODE_NW | vsce_pkg::MODE_ND | am |
                             strobe_code(r.addr));
                    add_word(r.mask); add_word(a2);
                end
                vsce_pkg::ACT_COUNTRD16: begin
                    add_word(vsce_pkg::MODE_NW | vsce_pkg::MODE_ND | am); add_word(r.mask);
                    add_word(a2);
                end
                default: begin
                    add_word(vsce_pkg::MODE_NW | vsce_pkg::MODE_ND | am); add_word(r.mask);
                    add_word(a4);
                end
            endcase
            foreach (burst[k]) begin
                e.word = burst[k];
                e.last = (k == burst.size() - 1);
                expected_words.insert(expected_words.size(), e);
            end
        endfunction

        // compare one accepted stack word with the oldest expectation
        function void check_word(logic [31:0] word, logic last);
            t_stack_entry e;
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("tb: unexpected stack word %08h last %0b", word, last);
                return;
            end
            e = expected_words.pop_front();
            if (word !== e.word || last !== e.last) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("tb: stack word mismatch: expected %08h last %0b, got %08h last %0b",
                             e.word, e.last, word, last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycles = 0;

    stack_word_board board;

    vsce_req_if req_ch ();
    vsce_rsp_if rsp_ch ();

    vme_stack_command_encoder #(
        .COUNT_WIDTH (DUT_COUNT_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_word(rsp_ch.stack_word, rsp_ch.last_word);
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // present one request and hold it until accepted
    task automatic send_request(input t_bus_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.action         <= r.action;
        req_ch.bus_address    <= r.addr;
        req_ch.addr_modifier  <= r.am;
        req_ch.data_value     <= r.data;
        req_ch.transfer_count <= r.count;
        req_ch.count_mask     <= r.mask;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(r);
    endtask

    task automatic send_fields(input vsce_pkg::t_action act, input logic [31:0] addr,
                               input logic [5:0] am, input logic [31:0] data,
                               input logic [23:0] count, input logic [31:0] mask);
        t_bus_request r;
        r.action = act;
        r.addr   = addr;
        r.am     = am;
        r.data   = data;
        r.count  = count;
        r.mask   = mask;
        send_request(r);
    endtask

    // random request, weighted towards block reads and awkward addresses
    function automatic t_bus_request random_request();
        t_bus_request r;
        int           sel;
        if ($urandom_range(99) < 40)
            r.action = vsce_pkg::t_action'($urandom_range(vsce_pkg::ACT_FIFO16,
                                                          vsce_pkg::ACT_BLKRD32));
        else
            r.action = vsce_pkg::t_action'($urandom_range(15));
        r.addr = $urandom();
        sel    = $urandom_range(3);
        case (sel)
            0:       r.addr[7:0] = 8'h00;
            1:       r.addr[7:0] = 8'(8'hf0 + $urandom_range(15));
            2:       r.addr[31:8] = 24'hff_ffff;
            default: ;
        endcase
        r.am   = 6'($urandom());
        r.data = $urandom();
        r.mask = $urandom();
        sel    = $urandom_range(99);
        if (sel < 10)      r.count = '0;
        else if (sel < 50) r.count = 24'($urandom_range(20));
        else if (sel < 85) r.count = 24'($urandom_range(600));
        else               r.count = 24'($urandom());
        return r;
    endfunction

    // stimulus
    initial begin
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.action         <= vsce_pkg::ACT_REGRD;
        req_ch.bus_address    <= '0;
        req_ch.addr_modifier  <= '0;
        req_ch.data_value     <= '0;
        req_ch.transfer_count <= '0;
        req_ch.count_mask     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every operation and the corner cases of the encoding
        send_fields(vsce_pkg::ACT_REGRD,
                    32'hffff_ffff, 6'h00, 32'h0,         24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_REGWR,
                    32'h0000_0000, 6'h3f, 32'hffff_ffff, 24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_WR32,
                    32'hffff_ffff, 6'h3f, 32'ha5a5_5a5a, 24'hff_ffff, 32'h0);
        send_fields(vsce_pkg::ACT_WR16,
                    32'h1234_5678, 6'h2d, 32'hffff_ffff, 24'h0,       32'h0);
        // byte writes on odd and even addresses
        send_fields(vsce_pkg::ACT_WR8,
                    32'h0000_0003, 6'h09, 32'h0000_01ff, 24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_WR8,
                    32'hffff_fffe, 6'h0d, 32'hffff_ff5a, 24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_RD32,
                    32'h8000_0003, 6'h39, 32'h0,         24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_RD16,
                    32'h0000_0000, 6'h29, 32'h0,         24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_RD8,
                    32'h0000_0001, 6'h3d, 32'h0,         24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_RD8,
                    32'hffff_fffe, 6'h00, 32'h0,         24'h0,       32'h0);
        // aligned block read of nothing
        send_fields(vsce_pkg::ACT_BLKRD32,
                    32'h0010_0000, 6'h0b, 32'h0,         24'h0,       32'h0);
        // unaligned start whose aligning count rounds to zero
        send_fields(vsce_pkg::ACT_BLKRD32,
                    32'h0010_00fd, 6'h0b, 32'h0,         24'd5,       32'h0);
        // largest count, address wraps past the top
        send_fields(vsce_pkg::ACT_BLKRD32,
                    32'hffff_ff10, 6'h3f, 32'h0,         24'hff_ffff, 32'h0);
        // count smaller than the aligning transfer
        send_fields(vsce_pkg::ACT_BLKRD32,
                    32'h0000_0080, 6'h0f, 32'h0,         24'd3,       32'h0);
        send_fields(vsce_pkg::ACT_BLKRD32,
                    32'h0000_0000, 6'h0f, 32'h0,         24'd64,      32'h0);
        // fifo reads keep the address fixed past the aligning transfer
        send_fields(vsce_pkg::ACT_FIFO32,
                    32'h0020_0000, 6'h0b, 32'h0,         24'd130,     32'h0);
        send_fields(vsce_pkg::ACT_FIFO16,
                    32'h0020_0001, 6'h0b, 32'h0,         24'd300,     32'h0);
        send_fields(vsce_pkg::ACT_FIFO16,
                    32'h0020_0000, 6'h0b, 32'h0,         24'd0,       32'h0);
        send_fields(vsce_pkg::ACT_FIFO32,
                    32'h0020_0044, 6'h0b, 32'h0,         24'd0,       32'h0);
        send_fields(vsce_pkg::ACT_DELAY,
                    32'h0,         6'h00, 32'hffff_ffff, 24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_MARKER,
                    32'h0,         6'h00, 32'hffff_ffff, 24'h0,       32'h0);
        send_fields(vsce_pkg::ACT_COUNTRD8,
                    32'h0000_0005, 6'h09, 32'h0,         24'h0,       32'h0000_00ff);
        send_fields(vsce_pkg::ACT_COUNTRD8,
                    32'h0000_0006, 6'h09, 32'h0,         24'h0,       32'h0000_ff00);
        send_fields(vsce_pkg::ACT_COUNTRD16,
                    32'hffff_ffff, 6'h3f, 32'h0,         24'h0,       32'hffff_ffff);
        send_fields(vsce_pkg::ACT_COUNTRD32,
                    32'hffff_ffff, 6'h00, 32'h0,         24'h0,       32'h0);

        // random requests, idling pattern changing every few dozen
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            case ((n / PHASE_LEN) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            send_request(random_request());
        end
        req_ch.valid <= 1'b0;

        // drain outstanding words, then watch for strays
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.failures == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
sv/vsce_pkg.sv
sv/vsce_if.sv
sv/vsce_front.sv
sv/vsce_queue.sv
sv/vsce_back.sv
sv/vme_stack_command_encoder.sv
verif/tb.sv
